/* rtl/mesi_crs_pkg.sv */
// Shared types and codes for the MESI cache request side.
// Holds the input/output word structs, line state and bus request codes.
// No dependencies.
`default_nettype none
package mesi_crs_pkg;

    localparam int DEF_WAYS         = 2;
    localparam int DEF_SETS         = 64;
    localparam int DEF_OFFSET_WIDTH = 5;
    localparam int DEF_COUNT_WIDTH  = 16;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    localparam logic [1:0] BUS_NONE = 2'd0;
    localparam logic [1:0] BUS_RD   = 2'd1;
    localparam logic [1:0] BUS_RDX  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic        held_elsewhere;
    } t_in_word;

    typedef struct packed {
        logic       hit;
        logic [2:0] way_used;
        logic [1:0] bus_request;
        logic [1:0] old_line_state;
        logic [1:0] new_line_state;
    } t_out_word;

endpackage
`default_nettype wire

/* rtl/mesi_cache_request_side.sv */
// MESI cache request side top level: address split, control and output register.
// Accepts a new access only when idle, so one access is in flight at a time; a stalled output
// keeps the lookup state. This follows from the read-modify-write of one set row in the set memory.
// Reset: synchronous; a clearing pass then writes every set row with the input stalled.
// Depends on mesi_crs_pkg, mesi_crs_array, mesi_crs_update.
`default_nettype none
module mesi_cache_request_side #(
    parameter int WAYS         = mesi_crs_pkg::DEF_WAYS,
    parameter int SETS         = mesi_crs_pkg::DEF_SETS,
    parameter int OFFSET_WIDTH = mesi_crs_pkg::DEF_OFFSET_WIDTH,
    parameter int COUNT_WIDTH  = mesi_crs_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output      logic                    o_in_stall,
    input  wire mesi_crs_pkg::t_in_word  i_in_word,
    output      logic                    o_out_valid,
    input  wire logic                    i_out_stall,
    output      mesi_crs_pkg::t_out_word o_out_word
);
    import mesi_crs_pkg::*;

    localparam int IDX_W   = $clog2(SETS);
    localparam int SET_W   = (IDX_W > 0) ? IDX_W : 1;
    localparam int TAG_W   = 32 - OFFSET_WIDTH - IDX_W;
    localparam int ENTRY_W = 2 + TAG_W + COUNT_WIDTH;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam logic [31:0] IDX_MASK = (32'd1 << IDX_W) - 32'd1;
    localparam logic [31:0] SETS32   = 32'(SETS);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [SET_W-1:0] r_clr_set;
    logic             r_kind;
    logic             r_held;
    logic [TAG_W-1:0] r_tag;
    logic [SET_W-1:0] r_set;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic [31:0]      field32;
    logic [31:0]      set32;
    logic [31:0]      tag32;
    logic [SET_W-1:0] in_set;
    logic             accept;
    logic             out_free;
    logic             finish;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] new_row;
    t_out_word        upd_word;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;

    always_comb begin
        field32 = (i_in_word.address >> OFFSET_WIDTH) & IDX_MASK;
        set32   = (field32 >= SETS32) ? field32 - SETS32 : field32;
        in_set  = set32[SET_W-1:0];
        tag32   = i_in_word.address >> (OFFSET_WIDTH + IDX_W);
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign finish     = (r_state == S_LOOK) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_set == LAST_SET) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_set   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_set <= r_clr_set + 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_in_word.kind;
            r_held <= i_in_word.held_elsewhere;
            r_tag  <= tag32[TAG_W-1:0];
            r_set  <= in_set;
        end
        if (finish) begin
            r_out_word <= upd_word;
        end
    end

    always_comb begin
        wr_en   = finish || (r_state == S_CLEAR);
        wr_addr = (r_state == S_CLEAR) ? r_clr_set : r_set;
        wr_data = (r_state == S_CLEAR) ? '0 : new_row;
    end

    mesi_crs_array #(
        .SETS  (SETS),
        .SET_W (SET_W),
        .ROW_W (ROW_W)
    ) u_array (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (in_set),
        .o_rd_data (rd_row),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    mesi_crs_update #(
        .WAYS        (WAYS),
        .TAG_W       (TAG_W),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ROW_W       (ROW_W)
    ) u_update (
        .i_kind           (r_kind),
        .i_held_elsewhere (r_held),
        .i_tag            (r_tag),
        .i_row            (rd_row),
        .o_row            (new_row),
        .o_word           (upd_word)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

/* rtl/mesi_crs_array.sv */
// Set memory: one row per set holding state, tag and use count of every way.
// Synchronous write, registered read. No package use.
`default_nettype none
module mesi_crs_array #(
    parameter int SETS  = 64,
    parameter int SET_W = 6,
    parameter int ROW_W = 78
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [SET_W-1:0] i_rd_addr,
    output      logic [ROW_W-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [SET_W-1:0] i_wr_addr,
    input  wire logic [ROW_W-1:0] i_wr_data
);

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* rtl/mesi_crs_update.sv */
// Lookup and update of one set row: hit search, victim choice, MESI transition.
// Depends on mesi_crs_pkg for state/bus codes and the output word struct.
`default_nettype none
module mesi_crs_update #(
    parameter int WAYS        = 2,
    parameter int TAG_W       = 21,
    parameter int COUNT_WIDTH = 16,
    parameter int ROW_W       = 78
) (
    input  wire logic                   i_kind,
    input  wire logic                   i_held_elsewhere,
    input  wire logic [TAG_W-1:0]       i_tag,
    input  wire logic [ROW_W-1:0]       i_row,
    output      logic [ROW_W-1:0]       o_row,
    output      mesi_crs_pkg::t_out_word o_word
);
    import mesi_crs_pkg::*;

    localparam int ENTRY_W = 2 + TAG_W + COUNT_WIDTH;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [1:0]             st   [WAYS];
    logic [TAG_W-1:0]       tg   [WAYS];
    logic [COUNT_WIDTH-1:0] cnt  [WAYS];
    logic                   hit;
    logic [WAY_W-1:0]       hit_way;
    logic [WAY_W-1:0]       vic_way;
    logic [COUNT_WIDTH-1:0] vic_cnt;
    logic [WAY_W-1:0]       way;
    logic [1:0]             old_st;
    logic [1:0]             new_st;
    logic [1:0]             bus;
    logic [COUNT_WIDTH-1:0] new_cnt;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            st[w]  = i_row[w*ENTRY_W + TAG_W + COUNT_WIDTH +: 2];
            tg[w]  = i_row[w*ENTRY_W + COUNT_WIDTH +: TAG_W];
            cnt[w] = i_row[w*ENTRY_W +: COUNT_WIDTH];
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (st[w] != ST_I && tg[w] == i_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        vic_way = '0;
        vic_cnt = cnt[0];
        for (int w = 1; w < WAYS; w++) begin
            if (cnt[w] < vic_cnt) begin
                vic_way = WAY_W'(w);
                vic_cnt = cnt[w];
            end
        end
    end

    always_comb begin
        way     = hit ? hit_way : vic_way;
        old_st  = ST_I;
        new_st  = ST_I;
        bus     = BUS_NONE;
        new_cnt = '0;
        if (hit) begin
            old_st  = st[hit_way];
            new_st  = old_st;
            new_cnt = (cnt[hit_way] == {COUNT_WIDTH{1'b1}}) ? cnt[hit_way]
                                                            : cnt[hit_way] + 1'b1;
            if (i_kind) begin
                new_st = ST_M;
                if (old_st == ST_S) begin
                    bus = BUS_RDX;
                end
            end
        end else if (i_kind) begin
            bus    = BUS_RDX;
            new_st = ST_M;
        end else begin
            bus    = BUS_RD;
            new_st = i_held_elsewhere ? ST_S : ST_E;
        end
    end

    always_comb begin
        o_row = i_row;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == way) begin
                o_row[w*ENTRY_W +: ENTRY_W] = {new_st, i_tag, new_cnt};
                if (hit) begin
                    o_row[w*ENTRY_W + COUNT_WIDTH +: TAG_W] = tg[w];
                end
            end
        end
    end

    always_comb begin
        o_word.hit            = hit;
        o_word.way_used       = 3'(way);
        o_word.bus_request    = bus;
        o_word.old_line_state = old_st;
        o_word.new_line_state = new_st;
    end

endmodule
`default_nettype wire

/* rtl/mesi_crs_checker.sv */
// Port-level checks for the MESI cache request side, bound to the top level.
// Depends on mesi_crs_pkg for codes and word structs.
`default_nettype none
module mesi_crs_checker (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire mesi_crs_pkg::t_in_word  i_in_word,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire mesi_crs_pkg::t_out_word o_out_word
);
    import mesi_crs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed or dropped");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted while one is in flight");

    a_miss_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.hit |->
            o_out_word.old_line_state == ST_I &&
            o_out_word.new_line_state != ST_I &&
            (o_out_word.bus_request == BUS_RD || o_out_word.bus_request == BUS_RDX))
        else $error("malformed miss result");

    a_hit_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.hit |->
            o_out_word.old_line_state != ST_I &&
            (o_out_word.bus_request == BUS_NONE ||
             (o_out_word.bus_request == BUS_RDX && o_out_word.old_line_state == ST_S &&
              o_out_word.new_line_state == ST_M)))
        else $error("malformed hit result");

endmodule

bind mesi_cache_request_side mesi_crs_checker u_mesi_crs_checker (.*);
`default_nettype wire
